FILE: hdl/assert_macros.svh
// Assertion shorthands shared by the top, MAC and control RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TBFE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbfe assertion failed");

// Next-cycle implication, off during reset.
`define TBFE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbfe assertion failed");

`endif

FILE: hdl/tbfe_pkg.sv
`default_nettype none
package tbfe_pkg;

  localparam int TAP_COUNT_DEF = 121;
  localparam int DATA_W        = 16;
  localparam int COEF_FRAC     = 15;
  localparam int GAIN_FRAC     = 12;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  localparam logic [1:0] REG_GAIN_LOW  = 2'd0;
  localparam logic [1:0] REG_GAIN_MID  = 2'd1;
  localparam logic [1:0] REG_GAIN_HIGH = 2'd2;

  localparam logic signed [DATA_W-1:0] GAIN_RESET = 16'sd4096;

  typedef struct packed {
    logic       mac;
    logic       scale;
    logic       first;
    logic [1:0] band;
  } tbfe_op_t;

endpackage
`default_nettype wire

FILE: hdl/three_band_fir_equalizer_unit.sv
// Three-band FIR equalizer.
// Input channel (in_valid / in_stall): one transaction is either an audio
// sample (opcode 0) or a coefficient write (opcode 1) into the low, mid or
// high bank at tap_number. A coefficient write gives no output. An audio
// sample is written into the circular delay line and runs three FIR
// passes through one shared multiplier, each pass followed by its gain
// multiply on the same multiplier.
// in_stall stays high while a sample is processed, until its result is
// loaded into the output register; a new sample is accepted only after
// the last one has been loaded.
// Output channel (out_valid / out_stall): sample_out sits in an output
// register; the next sample is accepted while it waits. If the receiver
// still stalls when the next result is ready, the block holds it and keeps
// in_stall high.
// Configuration: cfg_write with cfg_index 0..2 sets gain_low, gain_mid,
// gain_high (Q4.12); write only while idle.
// Reset: delay line reads as zero, write pointer zero, gains 1.0, no
// output pending. Coefficients must be written before use.
`default_nettype none
`include "assert_macros.svh"
module three_band_fir_equalizer_unit
  import tbfe_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     opcode,
  input  wire logic [1:0]               band_select,
  input  wire logic [6:0]               tap_number,
  input  wire logic signed [DATA_W-1:0] coefficient_value,
  input  wire logic signed [DATA_W-1:0] sample_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      sample_out,
  input  wire logic                     cfg_write,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  localparam int PTR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int CA_W  = $clog2(3 * TAP_COUNT);

  logic                     accept;
  logic                     busy;
  logic                     out_load;
  logic [PTR_W-1:0]         wp;
  logic [PTR_W-1:0]         rd_idx;
  logic [CA_W-1:0]          coef_addr;
  tbfe_op_t                 op;
  logic                     dl_we;
  logic                     cf_we;
  logic [CA_W-1:0]          cf_waddr;
  logic signed [DATA_W-1:0] dl_data;
  logic signed [DATA_W-1:0] cf_data;
  logic signed [DATA_W-1:0] result;
  logic signed [DATA_W-1:0] gain_low;
  logic signed [DATA_W-1:0] gain_mid;
  logic signed [DATA_W-1:0] gain_high;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign dl_we    = accept && (opcode == OP_SAMPLE);
  assign cf_we    = accept && (opcode == OP_COEF)
                 && (band_select == BAND_LOW || band_select == BAND_MID
                     || band_select == BAND_HIGH)
                 && (32'(tap_number) < TAP_COUNT);
  assign cf_waddr = CA_W'(band_select) * CA_W'(TAP_COUNT) + CA_W'(tap_number);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_low  <= GAIN_RESET;
      gain_mid  <= GAIN_RESET;
      gain_high <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_LOW:  gain_low  <= cfg_data;
        REG_GAIN_MID:  gain_mid  <= cfg_data;
        REG_GAIN_HIGH: gain_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= result;
    end
  end

  tbfe_ctrl #(.TAP_COUNT(TAP_COUNT)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (dl_we),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .busy      (busy),
    .out_load  (out_load),
    .wp        (wp),
    .rd_idx    (rd_idx),
    .coef_addr (coef_addr),
    .op        (op)
  );

  tbfe_delay_line #(.TAP_COUNT(TAP_COUNT)) u_delay (
    .clk   (clk),
    .rst   (rst),
    .we    (dl_we),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (rd_idx),
    .rdata (dl_data)
  );

  tbfe_coef_mem #(.TAP_COUNT(TAP_COUNT)) u_coef (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (coefficient_value),
    .raddr (coef_addr),
    .rdata (cf_data)
  );

  tbfe_mac #(.TAP_COUNT(TAP_COUNT)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .dl_data   (dl_data),
    .cf_data   (cf_data),
    .gain_low  (gain_low),
    .gain_mid  (gain_mid),
    .gain_high (gain_high),
    .result    (result)
  );

  `TBFE_ASSERT_IMP(a_no_overwrite, out_load, !(out_valid && out_stall))
  `TBFE_ASSERT_NXT(a_load_shows, out_load, out_valid)

endmodule
`default_nettype wire

FILE: hdl/tbfe_delay_line.sv
`default_nettype none
module tbfe_delay_line
  import tbfe_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF,
  localparam int PTR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [PTR_W-1:0]         waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [PTR_W-1:0]         raddr,
  output logic signed [DATA_W-1:0]      rdata
);

  logic signed [DATA_W-1:0] mem [TAP_COUNT];
  logic [TAP_COUNT-1:0]     valid;
  logic signed [DATA_W-1:0] rd_q;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  // unwritten entries read as zero
  assign rdata = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

FILE: hdl/tbfe_coef_mem.sv
`default_nettype none
module tbfe_coef_mem
  import tbfe_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF,
  localparam int DEPTH = 3 * TAP_COUNT,
  localparam int CA_W  = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [CA_W-1:0]          waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [CA_W-1:0]          raddr,
  output logic signed [DATA_W-1:0]      rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/tbfe_mac.sv
`default_nettype none
`include "assert_macros.svh"
module tbfe_mac
  import tbfe_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF,
  localparam int ACC_W = 33 + $clog2(TAP_COUNT),
  localparam int SH_W  = ACC_W - COEF_FRAC,
  localparam int P_W   = SH_W + DATA_W,
  localparam int TOT_W = P_W + 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire tbfe_op_t                 op,
  input  wire logic signed [DATA_W-1:0] dl_data,
  input  wire logic signed [DATA_W-1:0] cf_data,
  input  wire logic signed [DATA_W-1:0] gain_low,
  input  wire logic signed [DATA_W-1:0] gain_mid,
  input  wire logic signed [DATA_W-1:0] gain_high,
  output logic signed [DATA_W-1:0]      result
);

  tbfe_op_t                 ctl_a;
  tbfe_op_t                 ctl_b;
  logic signed [SH_W-1:0]   mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W-1:0] gain_sel;
  logic signed [P_W-1:0]    prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [TOT_W-1:0]  total;
  logic [TOT_W-DATA_W-GAIN_FRAC:0] hi;

  always_comb begin
    case (ctl_a.band)
      BAND_LOW:  gain_sel = gain_low;
      BAND_MID:  gain_sel = gain_mid;
      BAND_HIGH: gain_sel = gain_high;
      default:   gain_sel = '0;
    endcase
    if (ctl_a.scale) begin
      mul_a = acc[ACC_W-1:COEF_FRAC];
      mul_b = gain_sel;
    end else begin
      mul_a = {{(SH_W-DATA_W){dl_data[DATA_W-1]}}, dl_data};
      mul_b = cf_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
    end else begin
      ctl_a <= op;
      ctl_b <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctl_b.mac) begin
      acc <= ctl_b.first ? prod[ACC_W-1:0] : acc + prod[ACC_W-1:0];
    end
    if (ctl_b.scale) begin
      total <= ctl_b.first ? {{2{prod[P_W-1]}}, prod}
                           : total + {{2{prod[P_W-1]}}, prod};
    end
  end

  // floor shift by the gain fraction, then saturate
  assign hi = total[TOT_W-1:DATA_W+GAIN_FRAC-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      result = total[DATA_W+GAIN_FRAC-1:GAIN_FRAC];
    end else if (total[TOT_W-1]) begin
      result = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  `TBFE_ASSERT_IMP(a_op_excl, ctl_b.mac, !ctl_b.scale)

endmodule
`default_nettype wire

FILE: hdl/tbfe_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module tbfe_ctrl
  import tbfe_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF,
  localparam int PTR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1,
  localparam int CA_W  = $clog2(3 * TAP_COUNT)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  output logic                  busy,
  output logic                  out_load,
  output logic [PTR_W-1:0]      wp,
  output logic [PTR_W-1:0]      rd_idx,
  output logic [CA_W-1:0]       coef_addr,
  output tbfe_op_t              op
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_GAP    = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_DRAIN1 = 3'd4;
  localparam logic [2:0] S_DRAIN2 = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(TAP_COUNT - 1);

  logic [2:0]       state;
  logic [1:0]       band;
  logic [PTR_W-1:0] cnt;

  assign busy     = (state != S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    op = '0;
    case (state)
      S_MAC: begin
        op.mac   = 1'b1;
        op.first = (cnt == '0);
        op.band  = band;
      end
      S_SCALE: begin
        op.scale = 1'b1;
        op.first = (band == BAND_LOW);
        op.band  = band;
      end
      default: op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      band      <= BAND_LOW;
      cnt       <= '0;
      rd_idx    <= '0;
      coef_addr <= '0;
      wp        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            band      <= BAND_LOW;
            cnt       <= '0;
            rd_idx    <= wp;
            coef_addr <= '0;
            state     <= S_MAC;
          end
        end
        S_MAC: begin
          rd_idx    <= (rd_idx == '0) ? LAST : rd_idx - 1'b1;
          coef_addr <= coef_addr + 1'b1;
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_GAP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_GAP: state <= S_SCALE;
        S_SCALE: begin
          if (band == BAND_HIGH) begin
            state <= S_DRAIN1;
          end else begin
            band   <= band + 1'b1;
            cnt    <= '0;
            rd_idx <= wp;
            state  <= S_MAC;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            wp    <= (wp == LAST) ? '0 : wp + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TBFE_ASSERT_IMP(a_coef_addr, state == S_MAC,
    coef_addr == (CA_W'(band) * CA_W'(TAP_COUNT) + CA_W'(cnt)))
  `TBFE_ASSERT_IMP(a_band_start, state == S_MAC && cnt == '0, rd_idx == wp)

endmodule
`default_nettype wire
